// File: design/eye_shape_rasterizer_top_macros.svh
// assertion macros for the eye shape rasterizer
`ifndef EYE_SHAPE_RASTERIZER_TOP_MACROS_SVH
`define EYE_SHAPE_RASTERIZER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ESR_ASSERT(lbl_, clk_, rstn_, prop_) \
  lbl_: assert property (@(posedge clk_) disable iff (!rstn_) prop_) \
    else $error("esr assertion failed");
`define ESR_ASSERT_ALWAYS(lbl_, clk_, prop_) \
  lbl_: assert property (@(posedge clk_) prop_) else $error("esr assertion failed");
`else
`define ESR_ASSERT(lbl_, clk_, rstn_, prop_)
`define ESR_ASSERT_ALWAYS(lbl_, clk_, prop_)
`endif
`endif

// File: design/esr_pkg.sv
// types and constants shared by the eye shape rasterizer
`default_nettype none

package esr_pkg;

  localparam int unsigned PAGE_ROWS  = 8;
  localparam int unsigned ROW_W      = 3;
  // widest counters over the supported screen sizes
  localparam int unsigned ADDR_MAX_W = 12;
  localparam int unsigned COL_MAX_W  = 8;
  localparam int unsigned PAGE_MAX_W = 4;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_ROWS,
    ST_COLS,
    ST_DRAIN,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] center_x;
    logic [5:0] center_y;
    logic [5:0] radius_x;
    logic [5:0] radius_y;
    logic [6:0] eyelid_cut;
    logic [5:0] pupil_r;
    logic [9:0] byte_address;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] done_operation;
  } out_t;

  typedef struct packed {
    logic                  capture;
    logic                  setup_sq;
    logic                  setup_prod;
    logic                  row_en;
    logic [ROW_W-1:0]      row_idx;
    logic [PAGE_MAX_W-1:0] page;
    logic                  col_en;
    logic [COL_MAX_W-1:0]  col;
    logic [ADDR_MAX_W-1:0] addr;
    logic                  clr_en;
    logic                  rd_en;
    logic                  load_out;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: design/esr_ctrl.sv
// sequencer for clear, draw and read transactions of the eye shape rasterizer
`default_nettype none

module esr_ctrl #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [1:0]      in_op_i,
  output logic                 in_stall_o,
  input  wire logic            out_stall_i,
  output logic                 out_valid_o,
  output esr_pkg::cmd_t        cmd_o,
  input  wire esr_pkg::sts_t   sts_i
);

  localparam int unsigned PAGES = (SCREEN_HEIGHT + esr_pkg::PAGE_ROWS - 1) / esr_pkg::PAGE_ROWS;
  localparam int unsigned DEPTH = SCREEN_WIDTH * PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(SCREEN_WIDTH);
  localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

  esr_pkg::state_e state_q, state_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [CW-1:0]   col_q, col_d;
  logic [PW-1:0]   page_q, page_d;
  logic [2:0]      step_q, step_d;
  logic            out_valid_q, out_valid_d;
  logic            last_addr, last_col, last_page, out_free;

  assign last_addr = (addr_q == AW'(DEPTH - 1));
  assign last_col  = (col_q == CW'(SCREEN_WIDTH - 1));
  assign last_page = (page_q == PW'(PAGES - 1));
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      esr_pkg::ST_INIT: begin
        if (last_addr) state_d = esr_pkg::ST_IDLE;
      end
      esr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_op_i)
            esr_pkg::OP_CLEAR: state_d = esr_pkg::ST_CLEAR;
            esr_pkg::OP_DRAW:  state_d = esr_pkg::ST_SETUP;
            esr_pkg::OP_READ:  state_d = esr_pkg::ST_READ;
            default:           state_d = esr_pkg::ST_DONE;
          endcase
        end
      end
      esr_pkg::ST_CLEAR: begin
        if (last_addr) state_d = esr_pkg::ST_DONE;
      end
      esr_pkg::ST_SETUP: begin
        if (step_q == 3'd1) state_d = esr_pkg::ST_ROWS;
      end
      esr_pkg::ST_ROWS: begin
        if (step_q == 3'd7) state_d = esr_pkg::ST_COLS;
      end
      esr_pkg::ST_COLS: begin
        if (last_col) state_d = esr_pkg::ST_DRAIN;
      end
      esr_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = last_page ? esr_pkg::ST_DONE : esr_pkg::ST_ROWS;
      end
      esr_pkg::ST_READ: state_d = esr_pkg::ST_DONE;
      esr_pkg::ST_DONE: begin
        if (out_free) state_d = esr_pkg::ST_IDLE;
      end
      default: state_d = esr_pkg::ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    addr_d = addr_q;
    col_d  = col_q;
    page_d = page_q;
    step_d = 3'd0;
    case (state_q)
      esr_pkg::ST_INIT, esr_pkg::ST_CLEAR: addr_d = addr_q + AW'(1);
      esr_pkg::ST_IDLE: begin
        addr_d = '0;
        page_d = '0;
      end
      esr_pkg::ST_SETUP: step_d = (step_q == 3'd1) ? 3'd0 : step_q + 3'd1;
      esr_pkg::ST_ROWS: begin
        step_d = step_q + 3'd1;
        col_d  = '0;
      end
      esr_pkg::ST_COLS: begin
        addr_d = addr_q + AW'(1);
        col_d  = last_col ? '0 : col_q + CW'(1);
      end
      esr_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) page_d = page_q + PW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = (state_q == esr_pkg::ST_IDLE) && in_valid_i;
    cmd_o.setup_sq   = (state_q == esr_pkg::ST_SETUP) && (step_q == 3'd0);
    cmd_o.setup_prod = (state_q == esr_pkg::ST_SETUP) && (step_q == 3'd1);
    cmd_o.row_en     = (state_q == esr_pkg::ST_ROWS);
    cmd_o.row_idx    = step_q;
    cmd_o.page       = esr_pkg::PAGE_MAX_W'(page_q);
    cmd_o.col_en     = (state_q == esr_pkg::ST_COLS);
    cmd_o.col        = esr_pkg::COL_MAX_W'(col_q);
    cmd_o.addr       = esr_pkg::ADDR_MAX_W'(addr_q);
    cmd_o.clr_en     = (state_q == esr_pkg::ST_INIT) || (state_q == esr_pkg::ST_CLEAR);
    cmd_o.rd_en      = (state_q == esr_pkg::ST_READ);
    cmd_o.load_out   = (state_q == esr_pkg::ST_DONE) && out_free;
  end

  assign in_stall_o  = (state_q != esr_pkg::ST_IDLE);
  assign out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= esr_pkg::ST_INIT;
      addr_q      <= '0;
      col_q       <= '0;
      page_q      <= '0;
      step_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      col_q       <= col_d;
      page_q      <= page_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: design/esr_datapath.sv
// framebuffer memory, shape arithmetic and result register of the eye shape rasterizer
`default_nettype none

module esr_datapath #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire esr_pkg::cmd_t cmd_i,
  input  wire esr_pkg::in_t  in_data_i,
  output esr_pkg::sts_t      sts_o,
  output esr_pkg::out_t      out_data_o
);

  localparam int unsigned PAGES = (SCREEN_HEIGHT + esr_pkg::PAGE_ROWS - 1) / esr_pkg::PAGE_ROWS;
  localparam int unsigned DEPTH = SCREEN_WIDTH * PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(SCREEN_WIDTH);
  localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned YW    = PW + esr_pkg::ROW_W;
  localparam int unsigned DXW   = (CW > 7) ? CW : 7;
  localparam int unsigned DSQW  = 2 * DXW;
  localparam int unsigned BW    = DSQW + 12;
  localparam int unsigned ESW   = ((BW > 26) ? BW : 26) + 1;
  localparam int unsigned PSW   = ((DSQW > 14) ? DSQW : 14) + 1;
  localparam int unsigned AXW   = ((AW > 10) ? AW : 10) + 1;

  esr_pkg::in_t in_q;
  esr_pkg::out_t out_q;

  logic [11:0]       rx2_q, ry2_q, pr2_q;
  logic [23:0]       rxry2_q;
  logic signed [8:0] limit_q;

  // per-row terms of the current page
  logic [7:0]  ell_row_q, pup_row_q, set_row_q;
  logic [13:0] dysq_row_q [8];
  logic [25:0] a_row_q [8];
  logic        prep_v_q;
  logic [2:0]  prep_idx_q;
  logic [13:0] prep_dysq_q;

  logic [YW-1:0]     row_y;
  logic signed [8:0] row_dy;
  logic [6:0]        row_dy_abs;
  logic [13:0]       row_dysq;
  logic              row_on;

  // column pipeline
  logic signed [DXW:0] col_dx;
  logic [DXW-1:0]      col_dx_abs;
  logic                c1_v_q, c2_v_q;
  logic [DSQW-1:0]     c1_dxsq_q, c2_dxsq_q;
  logic                c1_ell_q, c1_pup_q, c2_ell_q, c2_pup_q;
  logic [AW-1:0]       c1_addr_q, c2_addr_q;
  logic [BW-1:0]       c2_b_q;

  logic [7:0]    mem_q [DEPTH];
  logic [7:0]    rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, new_byte;
  logic [7:0]    lane_pup, lane_ell;
  logic          in_range;

  // row term arithmetic
  assign row_y      = {cmd_i.page[PW-1:0], cmd_i.row_idx};
  assign row_dy     = $signed({{(9-YW){1'b0}}, row_y}) - $signed({3'd0, in_q.center_y});
  assign row_dy_abs = row_dy[8] ? 7'(-row_dy) : 7'(row_dy);
  assign row_dysq   = 14'(row_dy_abs) * 14'(row_dy_abs);
  assign row_on     = {1'b0, row_y} < (YW+1)'(SCREEN_HEIGHT);

  // column term arithmetic
  assign col_dx     = $signed({1'b0, DXW'(cmd_i.col[CW-1:0])})
                    - $signed({{(DXW+1-7){1'b0}}, in_q.center_x});
  assign col_dx_abs = col_dx[DXW] ? DXW'(-col_dx) : DXW'(col_dx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_data_i;
    if (cmd_i.setup_sq) begin
      rx2_q   <= 12'(in_q.radius_x) * 12'(in_q.radius_x);
      ry2_q   <= 12'(in_q.radius_y) * 12'(in_q.radius_y);
      pr2_q   <= 12'(in_q.pupil_r) * 12'(in_q.pupil_r);
      limit_q <= $signed({3'd0, in_q.center_y}) - $signed({3'd0, in_q.radius_y})
               + $signed({2'd0, in_q.eyelid_cut});
    end
    if (cmd_i.setup_prod) rxry2_q <= 24'(rx2_q) * 24'(ry2_q);
    if (cmd_i.row_en) begin
      ell_row_q[cmd_i.row_idx]  <= row_on && ({1'b0, row_dy_abs} <= {2'd0, in_q.radius_y});
      pup_row_q[cmd_i.row_idx]  <= row_on && ({1'b0, row_dy_abs} <= {2'd0, in_q.pupil_r});
      set_row_q[cmd_i.row_idx]  <= $signed({{(9-YW){1'b0}}, row_y}) >= limit_q;
      dysq_row_q[cmd_i.row_idx] <= row_dysq;
      prep_dysq_q               <= row_dysq;
      prep_idx_q                <= cmd_i.row_idx;
    end
    if (prep_v_q) a_row_q[prep_idx_q] <= 26'(prep_dysq_q) * 26'(rx2_q);
    if (cmd_i.col_en) begin
      c1_dxsq_q <= DSQW'(col_dx_abs) * DSQW'(col_dx_abs);
      c1_ell_q  <= col_dx_abs <= DXW'(in_q.radius_x);
      c1_pup_q  <= col_dx_abs <= DXW'(in_q.pupil_r);
      c1_addr_q <= cmd_i.addr[AW-1:0];
    end
    c2_b_q    <= BW'(c1_dxsq_q) * BW'(ry2_q);
    c2_dxsq_q <= c1_dxsq_q;
    c2_ell_q  <= c1_ell_q;
    c2_pup_q  <= c1_pup_q;
    c2_addr_q <= c1_addr_q;
    if (cmd_i.load_out) out_q <= {
      (in_q.operation == esr_pkg::OP_READ && in_range) ? rdata_q : 8'd0,
      in_q.operation
    };
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
      c1_v_q   <= 1'b0;
      c2_v_q   <= 1'b0;
    end else begin
      prep_v_q <= cmd_i.row_en;
      c1_v_q   <= cmd_i.col_en;
      c2_v_q   <= c1_v_q;
    end
  end

  // eight pixel tests of one byte
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      lane_pup[k] = pup_row_q[k] && c2_pup_q
                  && (PSW'(c2_dxsq_q) + PSW'(dysq_row_q[k]) <= PSW'(pr2_q));
      lane_ell[k] = ell_row_q[k] && c2_ell_q
                  && (ESW'(a_row_q[k]) + ESW'(c2_b_q) <= ESW'(rxry2_q));
      new_byte[k] = lane_pup[k] ? 1'b0 : (lane_ell[k] ? set_row_q[k] : rdata_q[k]);
    end
  end

  assign mem_we    = cmd_i.clr_en || c2_v_q;
  assign mem_waddr = cmd_i.clr_en ? cmd_i.addr[AW-1:0] : c2_addr_q;
  assign mem_wdata = cmd_i.clr_en ? 8'd0 : new_byte;
  assign mem_re    = cmd_i.rd_en || c1_v_q;
  assign mem_raddr = cmd_i.rd_en ? AW'(in_q.byte_address) : c1_addr_q;
  assign in_range  = AXW'(in_q.byte_address) < AXW'(DEPTH);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  assign sts_o.pipe_busy = prep_v_q || c1_v_q || c2_v_q;
  assign out_data_o      = out_q;

endmodule

`default_nettype wire

// File: design/eye_shape_rasterizer_top.sv
// Eye shape rasterizer: a 1-bit framebuffer in byte-wide pages of eight rows.
// Input channel in_valid_i/in_stall_o/in_data_i takes one operation per
// transaction: clear, draw eye or read byte. Output channel
// out_valid_o/out_stall_i/out_data_o returns one result per transaction
// (read data for an in-range read, zero otherwise, plus the operation code).
// One transaction is worked on at a time; in_stall_o is low only while idle.
// Work per operation, from acceptance to result valid:
//   read  fetches the addressed byte; an unused code goes straight to done
//   clear zeroes all DEPTH bytes, DEPTH = SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8)
//   draw  squares the radii, then per page row terms, columns and a drain
// The draw walks every framebuffer byte through a three-stage
// read-modify-write pipeline on the single memory port pair, testing eight
// pixels per byte, after the row terms of the page's eight rows.
// After reset a clearing pass writes every byte to zero with in_stall_o high.
// A result waits in the output register while out_stall_i is high; the next
// transaction may be accepted meanwhile but its result is held back until
// the register is free.
`default_nettype none
`include "eye_shape_rasterizer_top_macros.svh"

module eye_shape_rasterizer_top #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire esr_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output esr_pkg::out_t     out_data_o
);

  esr_pkg::cmd_t cmd;
  esr_pkg::sts_t sts;

  esr_ctrl #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.operation),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  esr_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_data_i),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

  `ESR_ASSERT(a_accept_then_busy, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)
  `ESR_ASSERT(a_result_after_drain, clk_i, rst_ni, cmd.load_out |-> !sts.pipe_busy)
  `ESR_ASSERT(a_no_result_overwrite, clk_i, rst_ni, cmd.load_out |-> !out_valid_o || !out_stall_i)
  `ESR_ASSERT(a_one_mem_cmd, clk_i, rst_ni, $onehot0({cmd.clr_en, cmd.row_en, cmd.col_en, cmd.rd_en}))
  `ESR_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |=> !out_valid_o)

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// self-checking testbench for the eye shape rasterizer with a framebuffer predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int SCREEN_W = 128;
  localparam int SCREEN_H = 64;
  localparam int PAGES    = (SCREEN_H + esr_pkg::PAGE_ROWS - 1) / esr_pkg::PAGE_ROWS;
  localparam int FB_BYTES = SCREEN_W * PAGES;
  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_LIMIT  = 8000;
  localparam int TAIL_CYCLES  = 40;
  localparam logic [1:0] OP_SPARE = 2'd3;

  class eye_scoreboard;
    logic [7:0]    fb_bytes [FB_BYTES];
    esr_pkg::out_t pending_q [$];
    int            faults;

    function new();
      foreach (fb_bytes[i]) fb_bytes[i] = '0;
      faults = 0;
    endfunction

    // update the framebuffer image and queue the result this transaction should give
    function void note_op(esr_pkg::in_t t);
      esr_pkg::out_t e;
      longint cx, cy, rx, ry, pr, lim, rx2, ry2, dx, dy, ax, ay;
      int     idx;
      bit     in_pupil, in_ellipse;
      e.read_data      = '0;
      e.done_operation = t.operation;
      case (t.operation)
        esr_pkg::OP_CLEAR: begin
          foreach (fb_bytes[i]) fb_bytes[i] = '0;
        end
        esr_pkg::OP_DRAW: begin
          cx  = longint'(t.center_x);
          cy  = longint'(t.center_y);
          rx  = longint'(t.radius_x);
          ry  = longint'(t.radius_y);
          pr  = longint'(t.pupil_r);
          lim = cy - ry + longint'(t.eyelid_cut);
          rx2 = rx * rx;
          ry2 = ry * ry;
          for (int y = 0; y < SCREEN_H; y++) begin
            dy = y - cy;
            ay = (dy < 0) ? -dy : dy;
            for (int x = 0; x < SCREEN_W; x++) begin
              dx = x - cx;
              ax = (dx < 0) ? -dx : dx;
              in_pupil   = ax <= pr && ay <= pr && dx * dx + dy * dy <= pr * pr;
              in_ellipse = ax <= rx && ay <= ry && dx * dx * ry2 + dy * dy * rx2 <= rx2 * ry2;
              if (in_pupil || in_ellipse) begin
                idx = (y / esr_pkg::PAGE_ROWS) * SCREEN_W + x;
                // pupil wins over the lid and the white
                if (!in_pupil && y >= lim)
                  fb_bytes[idx][y % esr_pkg::PAGE_ROWS] = 1'b1;
                else
                  fb_bytes[idx][y % esr_pkg::PAGE_ROWS] = 1'b0;
              end
            end
          end
        end
        esr_pkg::OP_READ: begin
          if (t.byte_address < FB_BYTES) e.read_data = fb_bytes[t.byte_address];
        end
        default: ;
      endcase
      pending_q.push_back(e);
    endfunction

    function void check_result(esr_pkg::out_t got);
      esr_pkg::out_t e;
      if (pending_q.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("tb_top: result with nothing outstanding: data %02h op %0d",
                   got.read_data, got.done_operation);
        return;
      end
      e = pending_q.pop_front();
      if (got.read_data !== e.read_data || got.done_operation !== e.done_operation) begin
        faults++;
        if (faults <= 10)
          $display("tb_top: mismatch: expected data %02h op %0d, got data %02h op %0d",
                   e.read_data, e.done_operation, got.read_data, got.done_operation);
      end
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  esr_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  esr_pkg::out_t out_data_o;

  eye_scoreboard sb = new();
  bit no_gaps = 1'b0;
  int sent    = 0;
  int quiet   = 0;

  eye_shape_rasterizer_top #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic esr_pkg::in_t noise_item();
    logic [63:0] raw;
    esr_pkg::in_t t;
    raw = {$urandom(), $urandom()};
    t = raw[$bits(esr_pkg::in_t)-1:0];
    return t;
  endfunction

  function automatic esr_pkg::in_t make_draw(int cx, int cy, int rx, int ry, int cut, int pr);
    esr_pkg::in_t t;
    t = noise_item();
    t.operation    = esr_pkg::OP_DRAW;
    t.center_x     = 7'(cx);
    t.center_y     = 6'(cy);
    t.radius_x     = 6'(rx);
    t.radius_y     = 6'(ry);
    t.eyelid_cut   = 7'(cut);
    t.pupil_r      = 6'(pr);
    return t;
  endfunction

  function automatic esr_pkg::in_t make_op(logic [1:0] op, int addr);
    esr_pkg::in_t t;
    t = noise_item();
    t.operation    = op;
    t.byte_address = 10'(addr);
    return t;
  endfunction

  // byte holding a pixel, with the pixel pulled onto the screen
  function automatic int byte_at(int col, int row);
    int c, r;
    c = (col < 0) ? 0 : (col >= SCREEN_W) ? SCREEN_W - 1 : col;
    r = (row < 0) ? 0 : (row >= SCREEN_H) ? SCREEN_H - 1 : row;
    return (r / esr_pkg::PAGE_ROWS) * SCREEN_W + c;
  endfunction

  task automatic send_op(esr_pkg::in_t t);
    no_gaps = (sent >= 200 && sent < 300);
    if (!no_gaps) begin
      while ($urandom_range(99) < 34) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_op(t);
    sent++;
  endtask

  // result side: check accepted transactions, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    out_stall_i <= !no_gaps && ($urandom_range(99) < 34);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int pick, cx, cy, rx, ry, cut, pr, reads;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty screen, shapes, lid, degenerate radii, clipping, spare code, clear
    send_op(make_op(esr_pkg::OP_READ, 0));
    send_op(make_op(esr_pkg::OP_READ, FB_BYTES - 1));
    send_op(make_draw(64, 32, 20, 12, 0, 4));
    send_op(make_op(esr_pkg::OP_READ, byte_at(64, 32)));
    send_op(make_op(esr_pkg::OP_READ, byte_at(64, 22)));
    send_op(make_op(esr_pkg::OP_READ, byte_at(50, 32)));
    send_op(make_draw(64, 32, 20, 12, 8, 0));
    send_op(make_op(esr_pkg::OP_READ, byte_at(64, 24)));
    send_op(make_draw(10, 20, 0, 10, 0, 0));
    send_op(make_op(esr_pkg::OP_READ, byte_at(10, 12)));
    send_op(make_op(esr_pkg::OP_READ, byte_at(10, 24)));
    send_op(make_draw(100, 40, 15, 0, 0, 0));
    send_op(make_op(esr_pkg::OP_READ, byte_at(100, 40)));
    send_op(make_op(esr_pkg::OP_READ, byte_at(86, 40)));
    send_op(make_draw(127, 63, 0, 0, 0, 0));
    send_op(make_op(esr_pkg::OP_READ, byte_at(127, 63)));
    send_op(make_draw(127, 63, 63, 63, 127, 63));
    send_op(make_op(esr_pkg::OP_READ, FB_BYTES - 1));
    send_op(make_draw(0, 0, 63, 63, 0, 0));
    send_op(make_op(esr_pkg::OP_READ, byte_at(0, 0)));
    send_op(make_op(esr_pkg::OP_READ, byte_at(60, 60)));
    send_op('1);
    send_op(make_op(esr_pkg::OP_CLEAR, 0));
    send_op(make_op(esr_pkg::OP_READ, byte_at(64, 32)));

    while (sent < RANDOM_ITEMS + 24) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        // draw then probe bytes, mostly around the eye
        cx  = $urandom_range(0, 127);
        cy  = $urandom_range(0, 63);
        rx  = $urandom_range(1) ? $urandom_range(0, 63) : $urandom_range(0, 16);
        ry  = $urandom_range(1) ? $urandom_range(0, 63) : $urandom_range(0, 16);
        cut = $urandom_range(1) ? $urandom_range(0, 2 * ry + 1) : $urandom_range(0, 127);
        pr  = $urandom_range(1) ? $urandom_range(0, ((rx < ry) ? rx : ry) + 2)
                                : $urandom_range(0, 63);
        send_op(make_draw(cx, cy, rx, ry, cut, pr));
        reads = $urandom_range(3, 8);
        repeat (reads) begin
          if ($urandom_range(9) == 0)
            send_op(make_op(esr_pkg::OP_READ, $urandom_range(0, FB_BYTES - 1)));
          else
            send_op(make_op(esr_pkg::OP_READ,
                            byte_at(cx + int'($urandom_range(0, 2 * rx + 2)) - rx - 1,
                                    cy + int'($urandom_range(0, 2 * ry + 2)) - ry - 1)));
        end
      end else if (pick < 82) begin
        send_op(make_op(esr_pkg::OP_READ, $urandom_range(0, FB_BYTES - 1)));
      end else if (pick < 89) begin
        send_op(make_op(esr_pkg::OP_CLEAR, 0));
      end else if (pick < 94) begin
        send_op(make_op(OP_SPARE, $urandom_range(0, FB_BYTES - 1)));
      end else begin
        send_op(make_draw($urandom_range(0, 127), $urandom_range(0, 63),
                          $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 127), $urandom_range(0, 63)));
      end
    end
    in_valid_i <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.faults == 0 && sb.outstanding() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
